// ===== rtl/timer_deadline_queue_assert.svh =====
// Assertion macros shared by the timer deadline queue RTL.
// Needs a clock and an active-low reset name at each use.
`ifndef TIMER_DEADLINE_QUEUE_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_ASSERT_SVH

// Check that an expression holds at every clock edge outside reset.
`define TDQ_ASSERT_ALWAYS(name, clk_sig, rstn_sig, expr, msg) \
  name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TDQ_ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdq_pkg.sv =====
// Shared types and constants of the timer deadline queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

  localparam int OpW       = 3;
  localparam int WordW     = 64;
  localparam int StatusW   = 2;
  localparam int CountW    = 5;
  localparam int MaxResults = 16;
  localparam int FireCntW  = 5;

  localparam logic [OpW-1:0] OP_ADD     = 3'd0;
  localparam logic [OpW-1:0] OP_RESCHED = 3'd1;
  localparam logic [OpW-1:0] OP_CANCEL  = 3'd2;
  localparam logic [OpW-1:0] OP_RUN_DUE = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;
  localparam logic [StatusW-1:0] ST_EXHAUSTED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic apply;
    logic emit;
  } tdq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_last;
  } tdq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tdq_in_if.sv =====
// Input channel of the timer deadline queue: handshake plus command item.
// Depends on tdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdq_pkg::OpW-1:0]       operation;
  logic [tdq_pkg::WordW-1:0]     timer_id;
  logic [tdq_pkg::WordW-1:0]     deadline;
  logic [tdq_pkg::WordW-1:0]     now_time;
  logic [tdq_pkg::WordW-1:0]     cutoff_id;

  modport source (output valid, output operation, output timer_id, output deadline,
                  output now_time, output cutoff_id, input ready);
  modport sink   (input valid, input operation, input timer_id, input deadline,
                  input now_time, input cutoff_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdq_out_if.sv =====
// Result channel of the timer deadline queue: handshake plus result item.
// Depends on tdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdq_pkg::StatusW-1:0]   status;
  logic [tdq_pkg::WordW-1:0]     result_id;
  logic                          fired;
  logic                          last;
  logic                          has_next;
  logic [tdq_pkg::WordW-1:0]     earliest_deadline;
  logic [tdq_pkg::CountW-1:0]    timer_count;
  logic [tdq_pkg::WordW-1:0]     last_added_id;

  modport source (output valid, output status, output result_id, output fired,
                  output last, output has_next, output earliest_deadline,
                  output timer_count, output last_added_id, input ready);
  modport sink   (input valid, input status, input result_id, input fired,
                  input last, input has_next, input earliest_deadline,
                  input timer_count, input last_added_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/timer_deadline_queue.sv =====
// One item at a time: a new item is accepted only in idle, once the last result of the
// previous item is taken. Each item makes two full passes over the table RAM, one for the
// lookup and one for the summary; each further run_due result adds an update and a pass.
// Reset: synchronous, active low; empties the table, sets the id counter to 1 and
// the last added id to 0. The table RAM itself is not cleared: per-slot valid bits gate it.
`timescale 1ns / 1ps
`default_nettype none

module timer_deadline_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tdq_in_if.sink     in_ch,
  tdq_out_if.source  out_ch
);

  tdq_pkg::tdq_cmd_t  cmd;
  tdq_pkg::tdq_stat_t stat;

  // Controller: accepts an item, runs a lookup pass over the table, applies the
  // update, runs a second pass for the summary fields, then presents the result.
  // A run_due item loops update, pass and result once per fired timer.
  tdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: timer table in RAM with valid bits in flops, the sequential scan
  // that finds the free slot, the id match, the earliest due timer and the
  // earliest deadline, plus the id counter and the registered result item.
  tdq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_operation          (in_ch.operation),
    .in_timer_id           (in_ch.timer_id),
    .in_deadline           (in_ch.deadline),
    .in_now_time           (in_ch.now_time),
    .in_cutoff_id          (in_ch.cutoff_id),
    .out_status            (out_ch.status),
    .out_result_id         (out_ch.result_id),
    .out_fired             (out_ch.fired),
    .out_last              (out_ch.last),
    .out_has_next          (out_ch.has_next),
    .out_earliest_deadline (out_ch.earliest_deadline),
    .out_timer_count       (out_ch.timer_count),
    .out_last_added_id     (out_ch.last_added_id)
  );

endmodule

`default_nettype wire

// ===== rtl/tdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tdq_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output      logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tdq_datapath.sv =====
// Datapath of the timer deadline queue: timer table, table scan, id counter
// and result register. Depends on tdq_pkg, tdq_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_deadline_queue_assert.svh"

module tdq_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tdq_pkg::tdq_cmd_t             cmd,
  output      tdq_pkg::tdq_stat_t            stat,
  input  wire logic [tdq_pkg::OpW-1:0]       in_operation,
  input  wire logic [tdq_pkg::WordW-1:0]     in_timer_id,
  input  wire logic [tdq_pkg::WordW-1:0]     in_deadline,
  input  wire logic [tdq_pkg::WordW-1:0]     in_now_time,
  input  wire logic [tdq_pkg::WordW-1:0]     in_cutoff_id,
  output      logic [tdq_pkg::StatusW-1:0]   out_status,
  output      logic [tdq_pkg::WordW-1:0]     out_result_id,
  output      logic                          out_fired,
  output      logic                          out_last,
  output      logic                          out_has_next,
  output      logic [tdq_pkg::WordW-1:0]     out_earliest_deadline,
  output      logic [tdq_pkg::CountW-1:0]    out_timer_count,
  output      logic [tdq_pkg::WordW-1:0]     out_last_added_id
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = tdq_pkg::WordW;
  localparam int EW = 2 * WW;
  localparam int FW = tdq_pkg::FireCntW;
  localparam int OW = tdq_pkg::OpW;
  localparam int SW = tdq_pkg::StatusW;
  localparam int NW = tdq_pkg::CountW;
  localparam logic [AW-1:0] LastAddr = AW'(CAPACITY - 1);
  localparam logic [FW-1:0] FireMax  = FW'(tdq_pkg::MaxResults);

  // Latched command item
  logic [OW-1:0] op_r, op_nxt;
  logic [WW-1:0] tid_r, tid_nxt, dl_r, dl_nxt, now_r, now_nxt, cutoff_r, cutoff_nxt;

  // Table state
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [WW-1:0]       id_ctr_r, id_ctr_nxt, recent_r, recent_nxt;

  // Scan sequencer
  logic          active_r, active_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          rd_v_r, rd_v_nxt, rd_last_r, rd_last_nxt, done_r, done_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;

  // Scan results
  logic          free_found_r, free_found_nxt, match_found_r, match_found_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt, match_idx_r, match_idx_nxt;
  logic          cand_found_r, cand_found_nxt;
  logic [AW-1:0] cand_idx_r, cand_idx_nxt;
  logic [WW-1:0] cand_id_r, cand_id_nxt, cand_dl_r, cand_dl_nxt;
  logic          any_r, any_nxt;
  logic [WW-1:0] min_dl_r, min_dl_nxt;

  // Pending result of the last update
  logic [SW-1:0] res_status_r, res_status_nxt;
  logic [WW-1:0] res_id_r, res_id_nxt;
  logic          res_fire_r, res_fire_nxt;
  logic [FW-1:0] fire_cnt_r, fire_cnt_nxt;

  // Result register
  logic [SW-1:0] out_status_r, out_status_nxt;
  logic [WW-1:0] out_id_r, out_id_nxt, out_next_dl_r, out_next_dl_nxt;
  logic [WW-1:0] out_added_r, out_added_nxt;
  logic          out_fired_r, out_fired_nxt, out_last_r, out_last_nxt;
  logic          out_has_next_r, out_has_next_nxt;
  logic [NW-1:0] out_count_r, out_count_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [WW-1:0] ent_id, ent_dl;
  logic          ent_v, ent_due, cand_better;

  tdq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign ent_id      = ram_rdata[EW-1:WW];
  assign ent_dl      = ram_rdata[WW-1:0];
  assign ent_v       = valid_r[rd_idx_r];
  assign ent_due     = (ent_dl <= now_r) && (ent_id <= cutoff_r);
  assign cand_better = (ent_dl < cand_dl_r) || ((ent_dl == cand_dl_r) && (ent_id < cand_id_r));

  always_comb begin
    op_nxt = op_r; tid_nxt = tid_r; dl_nxt = dl_r; now_nxt = now_r; cutoff_nxt = cutoff_r;
    valid_nxt = valid_r; count_nxt = count_r; id_ctr_nxt = id_ctr_r; recent_nxt = recent_r;
    active_nxt = active_r; addr_nxt = addr_r;
    free_found_nxt = free_found_r; free_idx_nxt = free_idx_r;
    match_found_nxt = match_found_r; match_idx_nxt = match_idx_r;
    cand_found_nxt = cand_found_r; cand_idx_nxt = cand_idx_r;
    cand_id_nxt = cand_id_r; cand_dl_nxt = cand_dl_r;
    any_nxt = any_r; min_dl_nxt = min_dl_r;
    res_status_nxt = res_status_r; res_id_nxt = res_id_r; res_fire_nxt = res_fire_r;
    fire_cnt_nxt = fire_cnt_r;
    out_status_nxt = out_status_r; out_id_nxt = out_id_r; out_fired_nxt = out_fired_r;
    out_last_nxt = out_last_r; out_has_next_nxt = out_has_next_r;
    out_next_dl_nxt = out_next_dl_r; out_count_nxt = out_count_r; out_added_nxt = out_added_r;
    ram_we = 1'b0;
    ram_waddr = free_idx_r;
    ram_wdata = {id_ctr_r, dl_r};

    if (cmd.load) begin
      op_nxt = in_operation;
      tid_nxt = in_timer_id;
      dl_nxt = in_deadline;
      now_nxt = in_now_time;
      cutoff_nxt = in_cutoff_id;
      fire_cnt_nxt = '0;
    end

    // Address side of the scan: one entry per cycle.
    rd_v_nxt = active_r;
    rd_idx_nxt = addr_r;
    rd_last_nxt = active_r && (addr_r == LastAddr);
    done_nxt = rd_v_r && rd_last_r;
    if (active_r) begin
      if (addr_r == LastAddr) begin
        active_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + AW'(1);
      end
    end

    // Data side of the scan: fold one entry into the running results.
    if (rd_v_r) begin
      if (!ent_v && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
      if (ent_v && (ent_id == tid_r)) begin
        match_found_nxt = 1'b1;
        match_idx_nxt = rd_idx_r;
      end
      if (ent_v && ent_due && (!cand_found_r || cand_better)) begin
        cand_found_nxt = 1'b1;
        cand_idx_nxt = rd_idx_r;
        cand_id_nxt = ent_id;
        cand_dl_nxt = ent_dl;
      end
      if (ent_v && (!any_r || (ent_dl < min_dl_r))) begin
        any_nxt = 1'b1;
        min_dl_nxt = ent_dl;
      end
    end

    if (cmd.scan_start) begin
      active_nxt = 1'b1;
      addr_nxt = '0;
      free_found_nxt = 1'b0;
      match_found_nxt = 1'b0;
      cand_found_nxt = 1'b0;
      any_nxt = 1'b0;
    end

    if (cmd.apply) begin
      res_status_nxt = tdq_pkg::ST_OK;
      res_id_nxt = '0;
      res_fire_nxt = 1'b0;
      case (op_r)
        tdq_pkg::OP_ADD: begin
          if (id_ctr_r == '0) begin
            res_status_nxt = tdq_pkg::ST_EXHAUSTED;
          end else if (!free_found_r) begin
            res_status_nxt = tdq_pkg::ST_FULL;
          end else begin
            ram_we = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = {id_ctr_r, dl_r};
            valid_nxt[free_idx_r] = 1'b1;
            count_nxt = count_r + CW'(1);
            id_ctr_nxt = id_ctr_r + WW'(1);
            recent_nxt = id_ctr_r;
            res_id_nxt = id_ctr_r;
          end
        end
        tdq_pkg::OP_RESCHED: begin
          if (!match_found_r) begin
            res_status_nxt = tdq_pkg::ST_NOT_FOUND;
          end else begin
            ram_we = 1'b1;
            ram_waddr = match_idx_r;
            ram_wdata = {tid_r, dl_r};
          end
        end
        tdq_pkg::OP_CANCEL: begin
          if (!match_found_r) begin
            res_status_nxt = tdq_pkg::ST_NOT_FOUND;
          end else begin
            valid_nxt[match_idx_r] = 1'b0;
            count_nxt = count_r - CW'(1);
          end
        end
        tdq_pkg::OP_RUN_DUE: begin
          if (cand_found_r && (fire_cnt_r < FireMax)) begin
            valid_nxt[cand_idx_r] = 1'b0;
            count_nxt = count_r - CW'(1);
            res_id_nxt = cand_id_r;
            res_fire_nxt = 1'b1;
            fire_cnt_nxt = fire_cnt_r + FW'(1);
          end
        end
        tdq_pkg::OP_CLEAR: begin
          valid_nxt = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.emit) begin
      out_status_nxt = res_status_r;
      out_id_nxt = res_id_r;
      out_fired_nxt = res_fire_r;
      out_last_nxt = !(res_fire_r && cand_found_r && (fire_cnt_r < FireMax));
      out_has_next_nxt = any_r;
      out_next_dl_nxt = any_r ? min_dl_r : '0;
      out_count_nxt = NW'(count_r);
      out_added_nxt = recent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      id_ctr_r <= WW'(1);
      recent_r <= '0;
      active_r <= 1'b0;
      rd_v_r <= 1'b0;
      rd_last_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      id_ctr_r <= id_ctr_nxt;
      recent_r <= recent_nxt;
      active_r <= active_nxt;
      rd_v_r <= rd_v_nxt;
      rd_last_r <= rd_last_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; tid_r <= tid_nxt; dl_r <= dl_nxt; now_r <= now_nxt; cutoff_r <= cutoff_nxt;
    addr_r <= addr_nxt;
    rd_idx_r <= rd_idx_nxt;
    free_found_r <= free_found_nxt; free_idx_r <= free_idx_nxt;
    match_found_r <= match_found_nxt; match_idx_r <= match_idx_nxt;
    cand_found_r <= cand_found_nxt; cand_idx_r <= cand_idx_nxt;
    cand_id_r <= cand_id_nxt; cand_dl_r <= cand_dl_nxt;
    any_r <= any_nxt; min_dl_r <= min_dl_nxt;
    res_status_r <= res_status_nxt; res_id_r <= res_id_nxt; res_fire_r <= res_fire_nxt;
    fire_cnt_r <= fire_cnt_nxt;
    out_status_r <= out_status_nxt; out_id_r <= out_id_nxt; out_fired_r <= out_fired_nxt;
    out_last_r <= out_last_nxt; out_has_next_r <= out_has_next_nxt;
    out_next_dl_r <= out_next_dl_nxt; out_count_r <= out_count_nxt; out_added_r <= out_added_nxt;
  end

  assign stat.scan_done = done_r;
  assign stat.out_last  = out_last_r;

  assign out_status            = out_status_r;
  assign out_result_id         = out_id_r;
  assign out_fired             = out_fired_r;
  assign out_last              = out_last_r;
  assign out_has_next          = out_has_next_r;
  assign out_earliest_deadline = out_next_dl_r;
  assign out_timer_count       = out_count_r;
  assign out_last_added_id     = out_added_r;

  `TDQ_ASSERT_ALWAYS(a_count_tracks_valid, clk, rst_n, $countones(valid_r) == int'(count_r), "timer count out of step with valid bits")
  `TDQ_ASSERT_ALWAYS(a_id_counter_ahead, clk, rst_n, id_ctr_r == recent_r + WW'(1), "id counter not one past last issued id")
  `TDQ_ASSERT_IMPLIES(a_no_scan_restart, clk, rst_n, cmd.scan_start, !active_r && !rd_v_r, "scan restarted while in flight")

endmodule

`default_nettype wire

// ===== rtl/tdq_ctrl.sv =====
// Controller of the timer deadline queue: sequences scan, update and result.
// Depends on tdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire tdq_pkg::tdq_stat_t   stat,
  output      tdq_pkg::tdq_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_APPLY = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (stat.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        if (stat.scan_done) begin
          cmd.emit = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = stat.out_last ? S_IDLE : S_APPLY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

`default_nettype wire
